FILE: sv/assert_macros.svh
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk and quiet during reset
`define ARTA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk and quiet during reset
`define ARTA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/arta_pkg.sv
// types and constants shared by the address resolution table blocks
`timescale 1ns / 1ps

package arta_pkg;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [15:0] TIMEOUT_RST = 16'd15;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [47:0] mac_out;
  } out_item_t;

  // one table entry as stored in memory
  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] stamp;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic time_inc;
    logic scan_en;
    logic do_write;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic eval_last;
  } sts_t;

endpackage

FILE: sv/arta_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module arta_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/arta_ctrl.sv
// controller state machine sequencing load, table scan, write and result
`timescale 1ns / 1ps

module arta_ctrl import arta_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] opcode,
  input  sts_t       sts,
  output cmd_t       cmd,
  output logic       busy,
  output logic       out_valid
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [1:0] op_r, op_nxt;
  logic       load;

  assign load = (state_r == ST_IDLE) && start;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt = opcode;
          if (opcode inside {OP_LOOKUP, OP_INSERT, OP_TICK}) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (sts.eval_last) begin
          state_nxt = (op_r == OP_INSERT) ? ST_WRITE : ST_DONE;
        end
      end
      ST_WRITE: state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_LOOKUP;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    cmd.load     = load;
    cmd.time_inc = load && (opcode == OP_TICK);
    cmd.scan_en  = (state_r == ST_SCAN);
    cmd.do_write = (state_r == ST_WRITE);
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

endmodule

FILE: sv/arta_dp.sv
// datapath: entry memory, valid bits, clock counter, scan and compare logic
`timescale 1ns / 1ps

module arta_dp import arta_pkg::*; #(
  parameter int unsigned N = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    in_item,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  cmd_t        cmd,
  output sts_t        sts,
  output out_item_t   out_item
);

  localparam int unsigned IW = $clog2(N);
  localparam int unsigned CW = $clog2(N + 1);

  in_item_t    item_r;
  logic [15:0] timeout_r;
  logic [31:0] time_r;
  logic [N-1:0] vld_r;
  logic [CW-1:0] cnt_r;
  logic          eval_vld_r;
  logic [IW-1:0] eval_idx_r;
  logic          hit_r;
  logic [47:0]   mac_r;
  logic          found_r;
  logic [IW-1:0] slot_r;
  logic          free_found_r;
  logic [IW-1:0] free_r;

  logic          issue;
  entry_t        rd_ent;
  entry_t        wr_ent;
  logic [IW-1:0] wslot;
  logic          ent_vld;
  logic          match;
  logic          expire;
  logic [31:0]   age;

  assign issue = cmd.scan_en && (cnt_r < CW'(N));
  assign wslot = found_r ? slot_r : (free_found_r ? free_r : '0);
  assign wr_ent = '{ip: item_r.ip_addr, mac: item_r.mac_addr, stamp: time_r};

  arta_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(N)
  ) u_tbl (
    .clk     (clk),
    .wr_en   (cmd.do_write),
    .wr_addr (wslot),
    .wr_data (wr_ent),
    .rd_en   (issue),
    .rd_addr (cnt_r[IW-1:0]),
    .rd_data (rd_ent)
  );

  // evaluate the entry read in the previous cycle
  assign ent_vld = vld_r[eval_idx_r];
  assign match   = eval_vld_r && ent_vld && (rd_ent.ip == item_r.ip_addr);
  assign age     = time_r - rd_ent.stamp;
  assign expire  = eval_vld_r && ent_vld && (age > {16'd0, timeout_r});

  assign sts.eval_last = eval_vld_r && (eval_idx_r == IW'(N - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= TIMEOUT_RST;
      time_r     <= '0;
      vld_r      <= '0;
      cnt_r      <= '0;
      eval_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout_r <= cfg_data;
      end
      if (cmd.time_inc) begin
        time_r <= time_r + 32'd1;
      end
      if (cmd.load) begin
        cnt_r <= '0;
      end else if (issue) begin
        cnt_r <= cnt_r + CW'(1);
      end
      eval_vld_r <= issue;
      if (cmd.do_write) begin
        vld_r[wslot] <= 1'b1;
      end else if (expire && (item_r.opcode == OP_TICK)) begin
        vld_r[eval_idx_r] <= 1'b0;
      end
    end
  end

  // item capture and scan results
  always_ff @(posedge clk) begin
    if (issue) begin
      eval_idx_r <= cnt_r[IW-1:0];
    end
    if (cmd.load) begin
      item_r       <= in_item;
      hit_r        <= 1'b0;
      mac_r        <= '0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      slot_r       <= '0;
      free_r       <= '0;
    end else if (eval_vld_r) begin
      if (match && !found_r) begin
        found_r <= 1'b1;
        slot_r  <= eval_idx_r;
        if (item_r.opcode == OP_LOOKUP) begin
          hit_r <= 1'b1;
          mac_r <= rd_ent.mac;
        end
      end
      if (!ent_vld && !free_found_r) begin
        free_found_r <= 1'b1;
        free_r       <= eval_idx_r;
      end
    end
  end

  assign out_item = '{hit: hit_r, mac_out: mac_r};

endmodule

FILE: sv/address_resolution_table_aging_unit.sv
// top level of the ipv4 to mac address resolution table with aging
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Address resolution table with aging. Holds TABLE_ENTRIES ipv4-to-mac
// entries in one entry memory plus a valid bit per entry in flip-flops,
// cleared at once by reset, so there is no clearing pass. An item is taken
// when start is high and busy is low; exactly one result follows, shown on
// out_item for a single cycle with out_valid high. The receiver cannot
// stall: sample the result in that cycle. A lookup, insert and tick each
// walk the whole table one entry per cycle through the memory read port;
// an insert then passes a further write state for the memory write, and
// an unused opcode goes straight to the result. busy stays high until the
// result, so the next item is taken only after it. Insert and tick items
// return hit=0 and mac_out=0. The timeout register is written through
// cfg_valid/cfg_ready/cfg_data and should be changed only while idle.
module address_resolution_table_aging_unit import arta_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // item channel
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  // result channel
  output logic        out_valid,
  output out_item_t   out_item,
  // timeout register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // sequencing: idle, scan, optional write, result strobe
  arta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .opcode    (in_item.opcode),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // table storage, compare, aging and result registers
  arta_dp #(
    .N(TABLE_ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

  // result strobe lasts one cycle
  `ARTA_ASSERT_NXT(a_strobe_single, out_valid, !out_valid, "result strobe held too long")
  // a result only appears while an item is in flight
  `ARTA_ASSERT_IMP(a_strobe_busy, out_valid, busy, "result strobe while idle")
  // a taken item makes the block busy
  `ARTA_ASSERT_NXT(a_accept_busy, start && !busy, busy, "item taken but not busy")
  // a miss carries a zero mac
  `ARTA_ASSERT_IMP(a_miss_zero, out_valid && !out_item.hit, out_item.mac_out == 48'd0, "miss with nonzero mac")

endmodule
